// ===== hdl/hrfs_pkg.sv =====
`timescale 1ns / 1ps
package hrfs_pkg;

  localparam int MaxRes = 4;

  // parse phase codes
  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_RL_WS     = 3'd1;
  localparam logic [2:0] PH_RL_TOK    = 3'd2;
  localparam logic [2:0] PH_HDR_START = 3'd3;
  localparam logic [2:0] PH_HDR_HELD  = 3'd4;
  localparam logic [2:0] PH_NAME      = 3'd5;
  localparam logic [2:0] PH_VALUE     = 3'd6;
  localparam logic [2:0] PH_DONE      = 3'd7;

  typedef enum logic [1:0] {
    EV_DATA    = 2'd0,
    EV_END     = 2'd1,
    EV_DROP    = 2'd2,
    EV_REQ_END = 2'd3
  } event_e;

  typedef enum logic [2:0] {
    FLD_METHOD  = 3'd0,
    FLD_PATH    = 3'd1,
    FLD_QUERY   = 3'd2,
    FLD_VERSION = 3'd3,
    FLD_HNAME   = 3'd4,
    FLD_HVALUE  = 3'd5
  } field_e;

  typedef struct packed {
    logic [2:0] phase;
    logic [1:0] tok;
    logic       query_seen;
    logic [7:0] held;
    logic [5:0] hdr_cnt;
    logic       ovf;
    logic       skip;
  } st_t;

  localparam st_t ST_RESET = '{
    phase: PH_IDLE, tok: 2'd0, query_seen: 1'b0, held: 8'd0,
    hdr_cnt: 6'd0, ovf: 1'b0, skip: 1'b0
  };

  typedef struct packed {
    event_e     ev;
    field_e     fld;
    logic [7:0] ch;
    logic [5:0] hidx;
    logic       ovf;
  } res_t;

  typedef struct packed {
    res_t [MaxRes-1:0] item;
    logic [2:0]        cnt;
  } res_list_t;

endpackage

// ===== hdl/http_request_field_splitter.sv =====
`timescale 1ns / 1ps
// path: input register, then result bank, which drives the output
// throughput: one byte per cycle while m_tready_i is high and each byte gives at most one
//   result; a byte that gives n results holds the result bank until all n are taken (n up to 4)
// reset: rst_ni asynchronous active low, clears parse state and both stage valids
module http_request_field_splitter #(
  parameter int MAX_HEADERS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [7:0]  s_tdata_i,   // char_in[7:0]
  input  logic        s_tlast_i,   // end_of_text
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [15:0] m_tdata_o,   // char_out[7:0], header_index[13:8],
                                   // header_overflow[14], zero pad[15]
  output logic [4:0]  m_tuser_o,   // event_res[1:0], field[4:2]
  output logic        m_tlast_o    // final_of_run
);
  import hrfs_pkg::*;

  localparam int HdrLimit = (MAX_HEADERS > 64) ? 64 : MAX_HEADERS;

  logic       in_valid_q;
  logic [7:0] in_char_q;
  logic       in_eot_q;
  st_t        state_q, state_d;
  res_list_t  list;
  logic       bank_free, process;

  assign process    = in_valid_q && bank_free;
  assign s_tready_o = !in_valid_q || bank_free;

  hrfs_step #(.MAX_HEADERS(MAX_HEADERS)) u_step (
    .state_i (state_q),
    .char_i  (in_char_q),
    .eot_i   (in_eot_q),
    .state_o (state_d),
    .list_o  (list)
  );

  hrfs_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (process),
    .list_i     (list),
    .free_o     (bank_free),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      state_q    <= ST_RESET;
    end else begin
      if (s_tvalid_i && s_tready_o) begin
        in_valid_q <= 1'b1;
      end else if (process) begin
        in_valid_q <= 1'b0;
      end
      if (process) state_q <= state_d;
    end
  end

  // input payload register
  always_ff @(posedge clk_i) begin
    if (s_tvalid_i && s_tready_o) begin
      in_char_q <= s_tdata_i;
      in_eot_q  <= s_tlast_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_eot_resets : assert property (@(posedge clk_i) disable iff (!rst_ni)
    process && in_eot_q |=> state_q.phase == PH_IDLE && state_q.hdr_cnt == 6'd0)
    else $error("parse state not cleared after end of text");

  a_ovf_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.ovf |-> state_q.hdr_cnt == 6'(HdrLimit - 1))
    else $error("overflow set without saturated header index");

  a_req_end_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o[1:0] == EV_REQ_END |-> m_tlast_o)
    else $error("request end is not the final result of its byte");
`endif

endmodule

// ===== hdl/hrfs_step.sv =====
`timescale 1ns / 1ps
module hrfs_step #(
  parameter int MAX_HEADERS = 64
) (
  input  hrfs_pkg::st_t      state_i,
  input  logic [7:0]         char_i,
  input  logic               eot_i,
  output hrfs_pkg::st_t      state_o,
  output hrfs_pkg::res_list_t list_o
);
  import hrfs_pkg::*;

  localparam int HdrLimit = (MAX_HEADERS > 64) ? 64 : MAX_HEADERS;

  typedef struct packed {
    st_t       st;
    res_list_t lst;
  } ctx_t;

  function automatic logic is_ws(logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0b || c == 8'h0c;
  endfunction

  function automatic ctx_t put(ctx_t x, event_e ev, field_e fld, logic [7:0] ch);
    ctx_t r;
    r = x;
    if (r.lst.cnt < 3'(MaxRes)) begin
      r.lst.item[r.lst.cnt[1:0]] = '{ev: ev, fld: fld, ch: ch, hidx: r.st.hdr_cnt,
                                     ovf: r.st.ovf};
      r.lst.cnt = r.lst.cnt + 3'd1;
    end
    return r;
  endfunction

  function automatic ctx_t tok_char(ctx_t x, logic [7:0] c);
    ctx_t r;
    r = x;
    case (r.st.tok)
      2'd0: r = put(r, EV_DATA, FLD_METHOD, c);
      2'd1: begin
        if (c == 8'h3f && !r.st.query_seen) begin
          r = put(r, EV_END, FLD_PATH, 8'd0);
          r.st.query_seen = 1'b1;
        end else begin
          r = put(r, EV_DATA, r.st.query_seen ? FLD_QUERY : FLD_PATH, c);
        end
      end
      2'd2: r = put(r, EV_DATA, FLD_VERSION, c);
      default: ;
    endcase
    return r;
  endfunction

  function automatic ctx_t tok_close(ctx_t x);
    ctx_t r;
    r = x;
    case (r.st.tok)
      2'd0: r = put(r, EV_END, FLD_METHOD, 8'd0);
      2'd1: r = put(r, EV_END, r.st.query_seen ? FLD_QUERY : FLD_PATH, 8'd0);
      2'd2: r = put(r, EV_END, FLD_VERSION, 8'd0);
      default: ;
    endcase
    return r;
  endfunction

  function automatic ctx_t line_char(ctx_t x, logic [7:0] c);
    ctx_t r;
    r = x;
    if (r.st.phase == PH_NAME) begin
      if (c == 8'h3a) begin
        r = put(r, EV_END, FLD_HNAME, 8'd0);
        r.st.phase = PH_VALUE;
        r.st.skip  = 1'b1;
      end else begin
        r = put(r, EV_DATA, FLD_HNAME, c);
      end
    end else if (r.st.skip) begin
      r.st.skip = 1'b0;
    end else begin
      r = put(r, EV_DATA, FLD_HVALUE, c);
    end
    return r;
  endfunction

  function automatic ctx_t header_done(ctx_t x);
    ctx_t r;
    r = x;
    r.st.skip = 1'b0;
    if ({1'b0, r.st.hdr_cnt} + 7'd1 < 7'(HdrLimit)) begin
      r.st.hdr_cnt = r.st.hdr_cnt + 6'd1;
    end else begin
      r.st.ovf = 1'b1;
    end
    return r;
  endfunction

  ctx_t c0, c1;
  logic lf;

  assign lf = (char_i == 8'h0a);

  always_comb begin
    c0     = '0;
    c0.st  = state_i;
    c1     = c0;
    unique case (state_i.phase)
      PH_IDLE: begin
        if (!lf) begin
          c1.st.tok        = 2'd0;
          c1.st.query_seen = 1'b0;
          if (is_ws(char_i)) begin
            c1.st.phase = PH_RL_WS;
          end else begin
            c1.st.phase = PH_RL_TOK;
            c1 = tok_char(c1, char_i);
          end
        end
      end
      PH_RL_WS: begin
        if (lf) begin
          c1.st.phase = PH_HDR_START;
        end else if (!is_ws(char_i)) begin
          c1.st.phase = PH_RL_TOK;
          c1 = tok_char(c1, char_i);
        end
      end
      PH_RL_TOK: begin
        if (lf) begin
          c1 = tok_close(c1);
          c1.st.phase = PH_HDR_START;
        end else if (is_ws(char_i)) begin
          c1 = tok_close(c1);
          if (c1.st.tok < 2'd3) c1.st.tok = c1.st.tok + 2'd1;
          c1.st.phase = PH_RL_WS;
        end else begin
          c1 = tok_char(c1, char_i);
        end
      end
      PH_HDR_START: begin
        if (!lf) begin
          c1.st.held  = char_i;
          c1.st.phase = PH_HDR_HELD;
        end
      end
      PH_HDR_HELD: begin
        if (lf) begin
          c1 = put(c1, EV_REQ_END, FLD_METHOD, 8'd0);
          c1.st.phase = PH_DONE;
        end else begin
          c1.st.phase = PH_NAME;
          c1.st.skip  = 1'b0;
          c1 = line_char(c1, state_i.held);
          c1 = line_char(c1, char_i);
        end
      end
      PH_NAME: begin
        if (lf) begin
          c1 = put(c1, EV_DROP, FLD_HNAME, 8'd0);
          c1.st.phase = PH_HDR_START;
        end else begin
          c1 = line_char(c1, char_i);
        end
      end
      PH_VALUE: begin
        if (lf) begin
          c1 = put(c1, EV_END, FLD_HVALUE, 8'd0);
          c1 = header_done(c1);
          c1.st.phase = PH_HDR_START;
        end else begin
          c1 = line_char(c1, char_i);
        end
      end
      default: ;
    endcase

    // close whatever field is open, end the request unless it already ended, then back to the reset state
    if (eot_i) begin
      case (c1.st.phase)
        PH_RL_TOK: c1 = tok_close(c1);
        PH_NAME:   c1 = put(c1, EV_DROP, FLD_HNAME, 8'd0);
        PH_VALUE: begin
          c1 = put(c1, EV_END, FLD_HVALUE, 8'd0);
          c1 = header_done(c1);
        end
        default: ;
      endcase
      if (c1.st.phase != PH_DONE) c1 = put(c1, EV_REQ_END, FLD_METHOD, 8'd0);
      c1.st = ST_RESET;
    end
  end

  assign state_o = c1.st;
  assign list_o  = c1.lst;

endmodule

// ===== hdl/hrfs_outq.sv =====
`timescale 1ns / 1ps
module hrfs_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  hrfs_pkg::res_list_t list_i,
  output logic                free_o,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output logic [15:0]         m_tdata_o,  // char_out[7:0], header_index[13:8],
                                          // header_overflow[14], zero pad[15]
  output logic [4:0]          m_tuser_o,  // event_res[1:0], field[4:2]
  output logic                m_tlast_o   // final_of_run
);
  import hrfs_pkg::*;

  res_t [MaxRes-1:0] items_q;
  logic [2:0]        cnt_q;
  logic [1:0]        idx_q;
  res_t              cur;
  logic              last, take;

  assign cur        = items_q[idx_q];
  assign last       = (idx_q == 2'(cnt_q - 3'd1));
  assign m_tvalid_o = (cnt_q != 3'd0);
  assign take       = m_tvalid_o && m_tready_i;
  assign free_o     = !m_tvalid_o || (take && last);

  assign m_tdata_o = {1'b0, cur.ovf, cur.hidx, cur.ch};
  assign m_tuser_o = {cur.fld, cur.ev};
  assign m_tlast_o = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
      idx_q <= 2'd0;
    end else if (load_i) begin
      cnt_q <= list_i.cnt;
      idx_q <= 2'd0;
    end else if (take) begin
      if (last) begin
        cnt_q <= 3'd0;
        idx_q <= 2'd0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) items_q <= list_i.item;
  end

endmodule
